FILE: rtl/core/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Types and codes shared by the serial link connection controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  // Event codes
  localparam logic [3:0] OP_ATTACH     = 4'd0;
  localparam logic [3:0] OP_DETACH     = 4'd1;
  localparam logic [3:0] OP_DATA       = 4'd2;
  localparam logic [3:0] OP_DISCOVERY  = 4'd3;
  localparam logic [3:0] OP_CONN_CONF  = 4'd4;
  localparam logic [3:0] OP_CONN_IND   = 4'd5;
  localparam logic [3:0] OP_DISCONNECT = 4'd6;
  localparam logic [3:0] OP_TICK       = 4'd7;
  localparam logic [3:0] OP_ANSWER     = 4'd8;

  // Command codes
  localparam logic [3:0] CMD_NONE        = 4'd0;
  localparam logic [3:0] CMD_DISCOVER    = 4'd1;
  localparam logic [3:0] CMD_QUERY_PARAM = 4'd2;
  localparam logic [3:0] CMD_QUERY_SEL   = 4'd3;
  localparam logic [3:0] CMD_QUERY_PRN   = 4'd4;
  localparam logic [3:0] CMD_CONNECT     = 4'd5;
  localparam logic [3:0] CMD_ACCEPT      = 4'd6;
  localparam logic [3:0] CMD_DISCONNECT  = 4'd7;
  localparam logic [3:0] CMD_FORWARD     = 4'd8;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BUSY    = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;

  // Initial parameter sets
  localparam logic [1:0] PRM_NONE  = 2'd0;
  localparam logic [1:0] PRM_3WIRE = 2'd1;
  localparam logic [1:0] PRM_9WIRE = 2'd2;

  // Service modes
  localparam logic [1:0] MODE_3WIRE_RAW = 2'd0;
  localparam logic [1:0] MODE_3WIRE     = 2'd1;

  // Directory answer kinds
  localparam logic [1:0] KIND_OCTETS  = 2'd0;
  localparam logic [1:0] KIND_INTEGER = 2'd1;

  // Invalid integer answer (-1 in nine bits)
  localparam logic [8:0] ANSWER_INVALID = 9'h1FF;

  // Configuration register indexes
  localparam logic [1:0] REG_SERVICE_MODE = 2'd0;
  localparam logic [1:0] REG_CTS_FLOW     = 2'd1;
  localparam logic [1:0] REG_WATCHDOG     = 2'd2;

  // Configuration reset values
  localparam logic [1:0]  SERVICE_MODE_RST = 2'd2;
  localparam logic [15:0] WATCHDOG_RST     = 16'd300;

  // Link state codes as reported
  localparam logic [2:0] LS_IDLE   = 3'd0;
  localparam logic [2:0] LS_SEARCH = 3'd1;
  localparam logic [2:0] LS_QPARAM = 3'd2;
  localparam logic [2:0] LS_QSEL   = 3'd3;
  localparam logic [2:0] LS_SETUP  = 3'd4;
  localparam logic [2:0] LS_READY  = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_QPARAM = 6'b000100,
    S_QSEL   = 6'b001000,
    S_SETUP  = 6'b010000,
    S_READY  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [1:0]  service_mode;
    logic        cts_flow;
    logic [15:0] watchdog_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [31:0]       peer_addr_in;
    logic [31:0]       local_addr_in;
    logic              answer_ok;
    logic [1:0]        answer_kind;
    logic signed [8:0] answer_value;
  } ev_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  status;
    logic [1:0]  param_set;
    logic        link_up;
    logic        carrier_drop;
    logic [2:0]  link_state;
    logic        tx_stopped;
    logic [31:0] peer_addr;
    logic [31:0] local_addr;
    logic [7:0]  remote_selector;
  } res_t;

  // Reported code of a one-hot state
  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] c;
    case (s)
      S_IDLE:   c = LS_IDLE;
      S_SEARCH: c = LS_SEARCH;
      S_QPARAM: c = LS_QPARAM;
      S_QSEL:   c = LS_QSEL;
      S_SETUP:  c = LS_SETUP;
      S_READY:  c = LS_READY;
      default:  c = LS_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/slc_ev_if.sv
// ----------------------------------------------------------------------------
// slc_ev_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_ev_if;
  logic              valid;
  logic              ready;
  logic [3:0]        op;
  logic [31:0]       peer_addr_in;
  logic [31:0]       local_addr_in;
  logic              answer_ok;
  logic [1:0]        answer_kind;
  logic signed [8:0] answer_value;

  modport source (
    output valid, op, peer_addr_in, local_addr_in, answer_ok, answer_kind,
           answer_value,
    input  ready
  );
  modport sink (
    input  valid, op, peer_addr_in, local_addr_in, answer_ok, answer_kind,
           answer_value,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/slc_res_if.sv
// ----------------------------------------------------------------------------
// slc_res_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [1:0]  status;
  logic [1:0]  param_set;
  logic        link_up;
  logic        carrier_drop;
  logic [2:0]  link_state;
  logic        tx_stopped;
  logic [31:0] peer_addr;
  logic [31:0] local_addr;
  logic [7:0]  remote_selector;

  modport source (
    output valid, command, status, param_set, link_up, carrier_drop, link_state,
           tx_stopped, peer_addr, local_addr, remote_selector,
    input  ready
  );
  modport sink (
    input  valid, command, status, param_set, link_up, carrier_drop, link_state,
           tx_stopped, peer_addr, local_addr, remote_selector,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/slc_cfg_if.sv
// ----------------------------------------------------------------------------
// slc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/slc_cfg.sv
// ----------------------------------------------------------------------------
// slc_cfg
// Configuration registers, written one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_cfg (
  input  wire logic   clk,
  input  wire logic   rst,
  slc_cfg_if.sink     cfg,
  output slc_pkg::cfg_t regs
);
  import slc_pkg::*;

  logic [1:0]  service_mode;
  logic        cts_flow;
  logic [15:0] watchdog_ticks;

  // Always able to take a write
  assign cfg.ready = 1'b1;

  // Register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      service_mode   <= SERVICE_MODE_RST;
      cts_flow       <= 1'b0;
      watchdog_ticks <= WATCHDOG_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SERVICE_MODE: service_mode   <= cfg.data[1:0];
        REG_CTS_FLOW:     cts_flow       <= cfg.data[0];
        REG_WATCHDOG:     watchdog_ticks <= cfg.data;
        default:          ;
      endcase
    end
  end

  assign regs = '{service_mode: service_mode, cts_flow: cts_flow,
                  watchdog_ticks: watchdog_ticks};

endmodule

`default_nettype wire

FILE: rtl/core/slc_fsm.sv
// ----------------------------------------------------------------------------
// slc_fsm
// Connection state machine, watchdog and stored peer data. Works out the
// result of one event combinationally and commits the state on step.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_fsm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire slc_pkg::ev_t  ev,
  input  wire slc_pkg::cfg_t regs,
  output slc_pkg::res_t      res
);
  import slc_pkg::*;

  state_t      state, state_next;
  logic        query_busy, query_busy_next;
  logic [31:0] stored_peer, stored_peer_next;
  logic [31:0] stored_local, stored_local_next;
  logic [7:0]  stored_selector, stored_selector_next;
  logic [15:0] timer_count, timer_count_next;
  logic        timer_running, timer_running_next;
  logic        hold_tx, hold_tx_next;

  logic [3:0]  cmd;
  logic [1:0]  sts;
  logic [1:0]  prm;
  logic        up;
  logic        drop;
  logic [15:0] wd_load;
  logic [1:0]  link_prm;
  logic        in_search;

  // Watchdog reload value; zero acts as one
  assign wd_load = (regs.watchdog_ticks == 16'd0) ? 16'd1 : regs.watchdog_ticks;

  // Parameter set sent at link up; mode three counts as nine-wire
  assign link_prm = (regs.service_mode == MODE_3WIRE_RAW) ? PRM_NONE :
                    (regs.service_mode == MODE_3WIRE) ? PRM_3WIRE : PRM_9WIRE;

  assign in_search = (state == S_SEARCH);

  // Next state and result of the event in hand
  always_comb begin
    state_next           = state;
    query_busy_next      = query_busy;
    stored_peer_next     = stored_peer;
    stored_local_next    = stored_local;
    stored_selector_next = stored_selector;
    timer_count_next     = timer_count;
    timer_running_next   = timer_running;
    hold_tx_next         = hold_tx;
    cmd  = CMD_NONE;
    sts  = STS_OK;
    prm  = PRM_NONE;
    up   = 1'b0;
    drop = 1'b0;

    case (ev.op)
      OP_ATTACH: begin
        if (state != S_READY) begin
          hold_tx_next = 1'b1;
          if (state == S_IDLE) begin
            timer_count_next   = wd_load;
            timer_running_next = 1'b1;
            state_next         = S_SEARCH;
            cmd                = CMD_DISCOVER;
          end else begin
            sts = STS_INVALID;
          end
        end
      end
      OP_DETACH: begin
        query_busy_next = 1'b0;
        if (state == S_SETUP || state == S_READY) cmd = CMD_DISCONNECT;
        state_next           = S_IDLE;
        stored_peer_next     = '0;
        stored_local_next    = '0;
        stored_selector_next = '0;
      end
      OP_DATA: begin
        if (state == S_READY) cmd = CMD_FORWARD;
        else                  sts = STS_INVALID;
      end
      OP_DISCOVERY: begin
        if (state != S_IDLE && !in_search) begin
          sts = STS_INVALID;
        end else begin
          stored_peer_next  = ev.peer_addr_in;
          stored_local_next = ev.local_addr_in;
          if (query_busy) begin
            sts = STS_BUSY;
          end else begin
            query_busy_next    = 1'b1;
            timer_count_next   = wd_load;
            timer_running_next = 1'b1;
            if (in_search && regs.service_mode == MODE_3WIRE_RAW) begin
              cmd        = CMD_QUERY_PRN;
              state_next = S_QSEL;
            end else begin
              cmd        = CMD_QUERY_PARAM;
              state_next = S_QPARAM;
            end
          end
        end
      end
      OP_CONN_CONF, OP_CONN_IND: begin
        if ((ev.op == OP_CONN_CONF && state != S_SETUP) || state == S_READY) begin
          sts = STS_INVALID;
        end else begin
          if (ev.op == OP_CONN_IND) cmd = CMD_ACCEPT;
          timer_running_next = 1'b0;
          state_next         = S_READY;
          prm                = link_prm;
          up                 = 1'b1;
          if (!regs.cts_flow) hold_tx_next = 1'b0;
        end
      end
      OP_DISCONNECT: begin
        if (state == S_READY) begin
          state_next         = S_SEARCH;
          timer_count_next   = wd_load;
          timer_running_next = 1'b1;
          drop               = 1'b1;
        end else begin
          sts = STS_INVALID;
        end
      end
      OP_TICK: begin
        if (timer_running) begin
          if (timer_count <= 16'd1) begin
            timer_count_next   = '0;
            timer_running_next = 1'b0;
            // Watchdog expiry
            case (state)
              S_IDLE: ;
              S_SEARCH: begin
                timer_count_next   = wd_load;
                timer_running_next = 1'b1;
                cmd                = CMD_DISCOVER;
              end
              S_QPARAM, S_QSEL, S_SETUP: begin
                state_next         = S_SEARCH;
                timer_count_next   = wd_load;
                timer_running_next = 1'b1;
              end
              default: sts = STS_INVALID;
            endcase
          end else begin
            timer_count_next = timer_count - 16'd1;
          end
        end
      end
      OP_ANSWER: begin
        query_busy_next = 1'b0;
        if (ev.answer_ok) begin
          if (ev.answer_kind == KIND_OCTETS) begin
            if (state != S_QPARAM) begin
              sts = STS_INVALID;
            end else begin
              query_busy_next    = 1'b1;
              cmd                = CMD_QUERY_SEL;
              timer_count_next   = wd_load;
              timer_running_next = 1'b1;
              state_next         = S_QSEL;
            end
          end else if (ev.answer_kind == KIND_INTEGER) begin
            if (ev.answer_value != ANSWER_INVALID)
              stored_selector_next = ev.answer_value[7:0];
            if (state != S_QSEL) begin
              sts = STS_INVALID;
            end else begin
              cmd                = CMD_CONNECT;
              timer_count_next   = wd_load;
              timer_running_next = 1'b1;
              state_next         = S_SETUP;
            end
          end
        end
      end
      default: sts = STS_INVALID;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      query_busy    <= 1'b0;
      timer_count   <= '0;
      timer_running <= 1'b0;
      hold_tx       <= 1'b1;
    end else if (step) begin
      state         <= state_next;
      query_busy    <= query_busy_next;
      timer_count   <= timer_count_next;
      timer_running <= timer_running_next;
      hold_tx       <= hold_tx_next;
    end
  end

  // Stored peer data (cleared at reset as it is reported)
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_peer     <= '0;
      stored_local    <= '0;
      stored_selector <= '0;
    end else if (step) begin
      stored_peer     <= stored_peer_next;
      stored_local    <= stored_local_next;
      stored_selector <= stored_selector_next;
    end
  end

  assign res = '{command: cmd, status: sts, param_set: prm, link_up: up,
                 carrier_drop: drop, link_state: state_code(state_next),
                 tx_stopped: hold_tx_next, peer_addr: stored_peer_next,
                 local_addr: stored_local_next,
                 remote_selector: stored_selector_next};

endmodule

`default_nettype wire

FILE: rtl/core/serial_link_connect_fsm_top.sv
// ----------------------------------------------------------------------------
// serial_link_connect_fsm_top
// Connection-setup controller for a virtual serial link over infrared.
// ----------------------------------------------------------------------------
// One event per cycle is taken on evt while res is not stalled, and each gives
// exactly one result on res: the event is captured in an input register, the
// state machine works it out combinationally and the result lands in an
// output register while the state is committed. The input register refills
// while a result waits, so a stalled sink costs at most one further event.
// Configuration writes on cfg are always accepted and should only be made
// while no event is in flight.
`default_nettype none

module serial_link_connect_fsm_top (
  input  wire logic clk,
  input  wire logic rst,
  slc_cfg_if.sink   cfg,
  slc_ev_if.sink    evt,
  slc_res_if.source res
);
  import slc_pkg::*;

  cfg_t regs;
  ev_t  ev_reg;
  logic ev_valid;
  res_t step_res;
  res_t res_reg;
  logic res_valid;
  logic step;

  slc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Work the held event when the result register is free or draining
  assign step      = ev_valid && (!res_valid || res.ready);
  assign evt.ready = !ev_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (evt.ready) begin
      ev_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      ev_reg <= '{op: evt.op, peer_addr_in: evt.peer_addr_in,
                  local_addr_in: evt.local_addr_in, answer_ok: evt.answer_ok,
                  answer_kind: evt.answer_kind, answer_value: evt.answer_value};
    end
  end

  slc_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ev   (ev_reg),
    .regs (regs),
    .res  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= step_res;
    end
  end

  assign res.valid           = res_valid;
  assign res.command         = res_reg.command;
  assign res.status          = res_reg.status;
  assign res.param_set       = res_reg.param_set;
  assign res.link_up         = res_reg.link_up;
  assign res.carrier_drop    = res_reg.carrier_drop;
  assign res.link_state      = res_reg.link_state;
  assign res.tx_stopped      = res_reg.tx_stopped;
  assign res.peer_addr       = res_reg.peer_addr;
  assign res.local_addr      = res_reg.local_addr;
  assign res.remote_selector = res_reg.remote_selector;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial link connection controller: directed
// event sequences through every state, then random sessions under several
// handshake idling patterns, each result checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import slc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // Codes the controller has no name for
  localparam logic [3:0] OP_UNDEFINED  = 4'd15;
  localparam logic [1:0] KIND_MISSING  = 2'd2;
  localparam logic [1:0] MODE_9WIRE    = 2'd2;
  localparam logic [1:0] MODE_UNLISTED = 2'd3;

  logic clk;
  logic rst;

  slc_cfg_if cfg_bus ();
  slc_ev_if  ev_bus ();
  slc_res_if res_bus ();

  serial_link_connect_fsm_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .evt (ev_bus),
    .res (res_bus)
  );

  // Predictor configuration and state, reset values
  logic [1:0]  c_mode  = SERVICE_MODE_RST;
  logic        c_cts   = 1'b0;
  logic [15:0] c_wd    = WATCHDOG_RST;
  logic [2:0]  ls      = LS_IDLE;
  logic        q_busy  = 1'b0;
  logic [31:0] s_peer  = '0;
  logic [31:0] s_local = '0;
  logic [7:0]  s_sel   = '0;
  logic [15:0] wd_count = '0;
  logic        wd_run  = 1'b0;
  logic        hold    = 1'b1;
  res_t        nxt;

  res_t expected_q[$];
  int   errors      = 0;
  int   cycle_count = 0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[serial_link_connect_fsm_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void wd_load();
    wd_count = (c_wd == 16'd0) ? 16'd1 : c_wd;
    wd_run   = 1'b1;
  endfunction

  function automatic void link_open();
    wd_run = 1'b0;
    ls     = LS_READY;
    case (c_mode)
      MODE_3WIRE_RAW: nxt.param_set = PRM_NONE;
      MODE_3WIRE:     nxt.param_set = PRM_3WIRE;
      default:        nxt.param_set = PRM_9WIRE;
    endcase
    nxt.link_up = 1'b1;
    if (!c_cts) hold = 1'b0;
  endfunction

  // Advance the controller by one event and return its result
  function automatic res_t link_step(input ev_t e);
    nxt = '0;
    case (e.op)
      OP_ATTACH: begin
        if (ls != LS_READY) begin
          hold = 1'b1;
          if (ls == LS_IDLE) begin
            wd_load();
            ls = LS_SEARCH;
            nxt.command = CMD_DISCOVER;
          end else begin
            nxt.status = STS_INVALID;
          end
        end
      end
      OP_DETACH: begin
        q_busy = 1'b0;
        if (ls == LS_SETUP || ls == LS_READY) nxt.command = CMD_DISCONNECT;
        ls      = LS_IDLE;
        s_peer  = '0;
        s_local = '0;
        s_sel   = '0;
      end
      OP_DATA: begin
        if (ls == LS_READY) nxt.command = CMD_FORWARD;
        else nxt.status = STS_INVALID;
      end
      OP_DISCOVERY: begin
        if (ls != LS_IDLE && ls != LS_SEARCH) begin
          nxt.status = STS_INVALID;
        end else begin
          s_peer  = e.peer_addr_in;
          s_local = e.local_addr_in;
          if (q_busy) begin
            nxt.status = STS_BUSY;
          end else begin
            q_busy = 1'b1;
            if (ls == LS_SEARCH && c_mode == MODE_3WIRE_RAW) begin
              nxt.command = CMD_QUERY_PRN;
              ls = LS_QSEL;
            end else begin
              nxt.command = CMD_QUERY_PARAM;
              ls = LS_QPARAM;
            end
            wd_load();
          end
        end
      end
      OP_CONN_CONF: begin
        if (ls == LS_SETUP) link_open();
        else nxt.status = STS_INVALID;
      end
      OP_CONN_IND: begin
        if (ls == LS_READY) begin
          nxt.status = STS_INVALID;
        end else begin
          nxt.command = CMD_ACCEPT;
          link_open();
        end
      end
      OP_DISCONNECT: begin
        if (ls == LS_READY) begin
          ls = LS_SEARCH;
          wd_load();
          nxt.carrier_drop = 1'b1;
        end else begin
          nxt.status = STS_INVALID;
        end
      end
      OP_TICK: begin
        if (wd_run) begin
          if (wd_count <= 16'd1) begin
            // watchdog expiry
            wd_count = '0;
            wd_run   = 1'b0;
            case (ls)
              LS_IDLE: ;
              LS_SEARCH: begin
                wd_load();
                nxt.command = CMD_DISCOVER;
              end
              LS_QPARAM, LS_QSEL, LS_SETUP: begin
                ls = LS_SEARCH;
                wd_load();
              end
              default: nxt.status = STS_INVALID;
            endcase
          end else begin
            wd_count = wd_count - 16'd1;
          end
        end
      end
      OP_ANSWER: begin
        q_busy = 1'b0;
        if (e.answer_ok) begin
          if (e.answer_kind == KIND_OCTETS) begin
            if (ls != LS_QPARAM) begin
              nxt.status = STS_INVALID;
            end else begin
              q_busy = 1'b1;
              nxt.command = CMD_QUERY_SEL;
              wd_load();
              ls = LS_QSEL;
            end
          end else if (e.answer_kind == KIND_INTEGER) begin
            if (e.answer_value != ANSWER_INVALID) s_sel = e.answer_value[7:0];
            if (ls != LS_QSEL) begin
              nxt.status = STS_INVALID;
            end else begin
              nxt.command = CMD_CONNECT;
              wd_load();
              ls = LS_SETUP;
            end
          end
        end
      end
      default: nxt.status = STS_INVALID;
    endcase
    nxt.link_state      = ls;
    nxt.tx_stopped      = hold;
    nxt.peer_addr       = s_peer;
    nxt.local_addr      = s_local;
    nxt.remote_selector = s_sel;
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_result(input res_t want);
    if (res_bus.command !== want.command)
      report("command", 32'(res_bus.command), 32'(want.command));
    if (res_bus.status !== want.status)
      report("status", 32'(res_bus.status), 32'(want.status));
    if (res_bus.param_set !== want.param_set)
      report("param_set", 32'(res_bus.param_set), 32'(want.param_set));
    if (res_bus.link_up !== want.link_up)
      report("link_up", 32'(res_bus.link_up), 32'(want.link_up));
    if (res_bus.carrier_drop !== want.carrier_drop)
      report("carrier_drop", 32'(res_bus.carrier_drop), 32'(want.carrier_drop));
    if (res_bus.link_state !== want.link_state)
      report("link_state", 32'(res_bus.link_state), 32'(want.link_state));
    if (res_bus.tx_stopped !== want.tx_stopped)
      report("tx_stopped", 32'(res_bus.tx_stopped), 32'(want.tx_stopped));
    if (res_bus.peer_addr !== want.peer_addr)
      report("peer_addr", res_bus.peer_addr, want.peer_addr);
    if (res_bus.local_addr !== want.local_addr)
      report("local_addr", res_bus.local_addr, want.local_addr);
    if (res_bus.remote_selector !== want.remote_selector)
      report("remote_selector", 32'(res_bus.remote_selector),
             32'(want.remote_selector));
  endtask

  // Result sink: random back-pressure, each transaction checked in order
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) begin
        if (expected_q.size() == 0) report("result with nothing expected", '0, '0);
        else check_result(expected_q.pop_front());
      end
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic ev_t make_event(input logic [3:0] op,
                                     input logic [31:0] peer = '0,
                                     input logic [31:0] loc_addr = '0,
                                     input logic ok = 1'b0,
                                     input logic [1:0] kind = '0,
                                     input logic [8:0] val = '0);
    ev_t e;
    e.op            = op;
    e.peer_addr_in  = peer;
    e.local_addr_in = loc_addr;
    e.answer_ok     = ok;
    e.answer_kind   = kind;
    e.answer_value  = val;
    return e;
  endfunction

  // One event transaction; valid stays high afterwards unless a gap follows
  task automatic send_event(input ev_t e);
    while ($urandom_range(99) < idle_pct) begin
      ev_bus.valid <= 1'b0;
      @(posedge clk);
    end
    ev_bus.valid         <= 1'b1;
    ev_bus.op            <= e.op;
    ev_bus.peer_addr_in  <= e.peer_addr_in;
    ev_bus.local_addr_in <= e.local_addr_in;
    ev_bus.answer_ok     <= e.answer_ok;
    ev_bus.answer_kind   <= e.answer_kind;
    ev_bus.answer_value  <= e.answer_value;
    do @(posedge clk); while (!ev_bus.ready);
    expected_q.push_back(link_step(e));
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_for_results();
    ev_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_SERVICE_MODE: c_mode = val[1:0];
      REG_CTS_FLOW:     c_cts  = val[0];
      default:          c_wd   = val;
    endcase
  endtask

  // Only called with no event in flight
  task automatic set_config(input logic [1:0] mode, input logic cts,
                            input logic [15:0] wd);
    write_reg(REG_SERVICE_MODE, {14'd0, mode});
    write_reg(REG_CTS_FLOW, {15'd0, cts});
    write_reg(REG_WATCHDOG, wd);
    cfg_bus.valid <= 1'b0;
  endtask

  // Mostly the event that moves the session on, otherwise noise and ticks
  function automatic ev_t pick_event();
    ev_t e;
    e.op            = 4'($urandom_range(15));
    e.peer_addr_in  = $urandom;
    e.local_addr_in = $urandom;
    e.answer_ok     = 1'($urandom_range(1));
    e.answer_kind   = 2'($urandom_range(3));
    e.answer_value  = 9'($urandom_range(511));
    if ($urandom_range(99) < 75) begin
      e.answer_ok = 1'b1;
      case (ls)
        LS_IDLE:   e.op = ($urandom_range(3) == 0) ? OP_CONN_IND : OP_ATTACH;
        LS_SEARCH: begin
          if (q_busy && $urandom_range(1)) e.op = OP_ANSWER;
          else e.op = ($urandom_range(3) == 0) ? OP_TICK : OP_DISCOVERY;
        end
        LS_QPARAM: begin
          e.op = OP_ANSWER;
          e.answer_kind = KIND_OCTETS;
        end
        LS_QSEL: begin
          e.op = OP_ANSWER;
          e.answer_kind = KIND_INTEGER;
          if ($urandom_range(7) == 0) e.answer_value = ANSWER_INVALID;
        end
        LS_SETUP:  e.op = OP_CONN_CONF;
        default: begin
          case ($urandom_range(3))
            0:       e.op = OP_DATA;
            1:       e.op = OP_DISCONNECT;
            2:       e.op = OP_DETACH;
            default: e.op = OP_TICK;
          endcase
        end
      endcase
    end else if ($urandom_range(1)) begin
      e.op = OP_TICK;
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset configuration: events that do nothing from idle
  task automatic test_idle_events();
    send_event(make_event(OP_DATA));
    send_event(make_event(OP_UNDEFINED));
    send_event(make_event(OP_TICK));
    wait_for_results();
  endtask

  // Full connection set-up and the events around an open link
  task automatic test_connect_flow();
    send_event(make_event(OP_ATTACH));
    send_event(make_event(OP_ATTACH));
    send_event(make_event(OP_DISCOVERY, 32'hFFFF_FFFF, 32'h0));
    send_event(make_event(OP_ANSWER, '0, '0, 1'b1, KIND_OCTETS));
    send_event(make_event(OP_ANSWER, '0, '0, 1'b1, KIND_INTEGER, 9'h0AB));
    send_event(make_event(OP_CONN_CONF));
    send_event(make_event(OP_DATA));
    send_event(make_event(OP_ATTACH));
    send_event(make_event(OP_CONN_IND));
    send_event(make_event(OP_DISCONNECT));
    send_event(make_event(OP_DETACH));
    wait_for_results();
  endtask

  // Shortest watchdog, printer mode, busy discovery and stray answers
  task automatic test_watchdog_and_busy();
    set_config(MODE_3WIRE_RAW, 1'b1, 16'd1);
    send_event(make_event(OP_ATTACH));
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_DISCOVERY, 32'h0, 32'hFFFF_FFFF));
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_DISCOVERY, 32'h1234_5678, 32'h9ABC_DEF0));
    send_event(make_event(OP_ANSWER, '0, '0, 1'b0, KIND_OCTETS));
    send_event(make_event(OP_ANSWER, '0, '0, 1'b1, KIND_MISSING));
    send_event(make_event(OP_ANSWER, '0, '0, 1'b1, KIND_INTEGER, 9'h155));
    send_event(make_event(OP_DETACH));
    wait_for_results();
  endtask

  // Zero watchdog, service mode three, carrier flow control at link up
  task automatic test_mode_variants();
    set_config(MODE_UNLISTED, 1'b1, 16'd0);
    send_event(make_event(OP_ATTACH));
    send_event(make_event(OP_DISCOVERY, 32'hA5A5_5A5A, 32'h5A5A_A5A5));
    send_event(make_event(OP_ANSWER, '0, '0, 1'b1, KIND_OCTETS));
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_CONN_IND));
    send_event(make_event(OP_TICK));
    send_event(make_event(OP_DETACH));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [1:0] mode, input logic cts,
                                     input logic [15:0] wd, input int n);
    wait_for_results();
    set_config(mode, cts, wd);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_event(pick_event());
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                  <= 1'b1;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    ev_bus.valid         <= 1'b0;
    ev_bus.op            <= '0;
    ev_bus.peer_addr_in  <= '0;
    ev_bus.local_addr_in <= '0;
    ev_bus.answer_ok     <= 1'b0;
    ev_bus.answer_kind   <= '0;
    ev_bus.answer_value  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_events();
    test_connect_flow();
    test_watchdog_and_busy();
    test_mode_variants();

    test_random_traffic(0, 0, MODE_3WIRE_RAW, 1'b0, 16'd1, 80);
    test_random_traffic(0, 0, MODE_3WIRE, 1'b1, 16'd3, 80);
    test_random_traffic(75, 0, MODE_9WIRE, 1'b0, 16'd2, 80);
    test_random_traffic(75, 0, MODE_UNLISTED, 1'b1, 16'd65535, 60);
    test_random_traffic(0, 75, 2'($urandom_range(3)), 1'($urandom_range(1)),
                        16'd0, 80);
    test_random_traffic(0, 75, MODE_3WIRE, 1'b0, 16'd4, 80);
    test_random_traffic(19, 19, MODE_3WIRE_RAW, 1'b1, 16'd2, 80);
    test_random_traffic(19, 19, 2'($urandom_range(3)), 1'($urandom_range(1)),
                        16'($urandom_range(1, 5)), 80);

    wait_for_results();
    if (errors == 0) begin
      $display("[serial_link_connect_fsm_top] OK");
    end else begin
      $display("[serial_link_connect_fsm_top] ERROR");
    end
    $finish;
  end

endmodule
